// ----- sv/closest_goldbach_prime_pair_defines.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef CLOSEST_GOLDBACH_PRIME_PAIR_DEFINES_SVH
`define CLOSEST_GOLDBACH_PRIME_PAIR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CGPP_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CGPP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/cgpp_pkg.sv -----
package cgpp_pkg;

  // Width of the number to split and of the larger prime
  localparam int NUM_WIDTH = 16;
  // The smaller prime never exceeds half the number
  localparam int SMALL_WIDTH = NUM_WIDTH - 1;
  // Bit counter for the serial remainder
  localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

  // Status of the serial remainder unit
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_stat_t;

  // Status of the trial-division prime tester
  typedef struct packed {
    logic busy;
    logic done;
    logic is_prime;
  } prime_stat_t;

endpackage

// ----- sv/cgpp_ifs.sv -----
interface cgpp_in_if;
  logic                           valid;
  logic                           ready;
  logic [cgpp_pkg::NUM_WIDTH-1:0] target_even;

  modport source (output valid, output target_even, input ready);
  modport sink (input valid, input target_even, output ready);
endinterface

interface cgpp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             valid_res;
  logic [cgpp_pkg::SMALL_WIDTH-1:0] smaller_prime;
  logic [cgpp_pkg::NUM_WIDTH-1:0]   larger_prime;

  modport source (output valid, output valid_res, output smaller_prime,
                  output larger_prime, input ready);
  modport sink (input valid, input valid_res, input smaller_prime,
                input larger_prime, output ready);
endinterface

// ----- sv/cgpp_rem.sv -----
// Restoring remainder, one dividend bit per cycle.
module cgpp_rem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cgpp_pkg::NUM_WIDTH-1:0] dividend,
  input  logic [cgpp_pkg::NUM_WIDTH-1:0] divisor,
  output cgpp_pkg::rem_stat_t            stat
);

  logic                           busy;
  logic                           done;
  logic [cgpp_pkg::CNT_WIDTH-1:0] cnt;
  logic [cgpp_pkg::NUM_WIDTH-1:0] rem;
  logic [cgpp_pkg::NUM_WIDTH-1:0] dv;
  logic [cgpp_pkg::NUM_WIDTH-1:0] dsr;
  logic [cgpp_pkg::NUM_WIDTH:0]   trial;
  logic [cgpp_pkg::NUM_WIDTH:0]   diff;
  logic [cgpp_pkg::NUM_WIDTH-1:0] rem_next;

  // Bring down the next dividend bit and subtract if it fits
  always_comb begin
    trial = {rem, dv[cgpp_pkg::NUM_WIDTH-1]};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      rem_next = diff[cgpp_pkg::NUM_WIDTH-1:0];
    end else begin
      rem_next = trial[cgpp_pkg::NUM_WIDTH-1:0];
    end
  end

  // Control: count the bits down
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= cgpp_pkg::CNT_WIDTH'(cgpp_pkg::NUM_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == cgpp_pkg::CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend out, update the partial remainder
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      dv  <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dv  <= {dv[cgpp_pkg::NUM_WIDTH-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.zero = (rem == '0);

endmodule

// ----- sv/cgpp_prime_test.sv -----
// Trial division of one candidate by 2, 3, ... while d*d <= candidate.
module cgpp_prime_test (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cgpp_pkg::NUM_WIDTH-1:0] cand_in,
  output cgpp_pkg::prime_stat_t          stat
);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_CHECK = 2'd1;
  localparam logic [1:0] T_DIV   = 2'd2;

  logic [1:0]                     state;
  logic                           done;
  logic                           is_prime;
  logic                           rem_start;
  logic [cgpp_pkg::NUM_WIDTH-1:0] cand;
  logic [cgpp_pkg::NUM_WIDTH-1:0] d;
  logic [cgpp_pkg::NUM_WIDTH:0]   sq;
  cgpp_pkg::rem_stat_t            rs;

  assign rem_start = (state == T_CHECK) && (sq <= {1'b0, cand});

  cgpp_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (cand),
    .divisor  (d),
    .stat     (rs)
  );

  // Sequence: check bound, divide, step divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      done     <= 1'b0;
      is_prime <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (start) begin
            state <= T_CHECK;
          end
        end
        T_CHECK: begin
          if (!rem_start) begin
            done     <= 1'b1;
            is_prime <= 1'b1;
            state    <= T_IDLE;
          end else begin
            state <= T_DIV;
          end
        end
        T_DIV: begin
          if (rs.done) begin
            if (rs.zero) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
              state    <= T_IDLE;
            end else begin
              state <= T_CHECK;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Divisor and its square, advanced by (d+1)^2 = d^2 + 2d + 1
  always_ff @(posedge clk) begin
    if (state == T_IDLE && start) begin
      cand <= cand_in;
      d    <= cgpp_pkg::NUM_WIDTH'(2);
      sq   <= (cgpp_pkg::NUM_WIDTH + 1)'(4);
    end else if (state == T_DIV && rs.done) begin
      d  <= d + 1'b1;
      sq <= sq + {d, 1'b1};
    end
  end

  assign stat.busy     = (state != T_IDLE);
  assign stat.done     = done;
  assign stat.is_prime = is_prime;

endmodule

// ----- sv/closest_goldbach_prime_pair.sv -----
// Odd input or input below 4 goes from S_IDLE straight to S_EMIT, then to the output
// register once the output slot is free. Otherwise each trial divisor runs one
// bit-serial remainder, with up to floor(sqrt(c)) - 1 divisors per candidate c,
// for the candidates walked down from n/2.
// Throughput: one item at a time; the next is taken once the result is loaded.
// Reset (synchronous, active high) clears control state; no clearing pass.
`include "closest_goldbach_prime_pair_defines.svh"

module closest_goldbach_prime_pair (
  input  logic       clk,
  input  logic       rst,
  cgpp_in_if.sink    in_ch,
  cgpp_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_TEST_P = 2'd1;
  localparam logic [1:0] S_TEST_Q = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]                       state;
  logic                             launch;
  logic                             res_ok;
  logic                             out_valid;
  logic [cgpp_pkg::NUM_WIDTH-1:0]   n_reg;
  logic [cgpp_pkg::SMALL_WIDTH-1:0] p;
  logic [cgpp_pkg::NUM_WIDTH-1:0]   q;
  logic [cgpp_pkg::NUM_WIDTH-1:0]   n_in;
  logic [cgpp_pkg::NUM_WIDTH-1:0]   cand;
  logic                             in_fire;
  logic                             in_bad;
  logic                             emit_fire;
  logic                             step;
  logic                             at_end;
  logic                             out_valid_res;
  logic [cgpp_pkg::SMALL_WIDTH-1:0] out_smaller;
  logic [cgpp_pkg::NUM_WIDTH-1:0]   out_larger;
  cgpp_pkg::prime_stat_t            pt;

  assign n_in      = in_ch.target_even;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_bad    = n_in[0] || ((n_in >> 2) == '0);
  assign emit_fire = (state == S_EMIT) && (!out_valid || out_ch.ready);
  // Move to the next lower p when either side of the pair is composite
  assign step      = pt.done && !pt.is_prime &&
                     ((state == S_TEST_P) || (state == S_TEST_Q));
  assign at_end    = (p == cgpp_pkg::SMALL_WIDTH'(2));
  assign cand      = (state == S_TEST_Q) ? q : {1'b0, p};

  cgpp_prime_test u_prime (
    .clk     (clk),
    .rst     (rst),
    .start   (launch),
    .cand_in (cand),
    .stat    (pt)
  );

  // Control: walk p downward, test p then n - p
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_bad) begin
              state <= S_EMIT;
            end else begin
              state  <= S_TEST_P;
              launch <= 1'b1;
            end
          end
        end
        S_TEST_P: begin
          if (pt.done && pt.is_prime) begin
            state  <= S_TEST_Q;
            launch <= 1'b1;
          end else if (step) begin
            if (at_end) begin
              state <= S_EMIT;
            end else begin
              launch <= 1'b1;
            end
          end
        end
        S_TEST_Q: begin
          if (pt.done && pt.is_prime) begin
            state <= S_EMIT;
          end else if (step) begin
            if (at_end) begin
              state <= S_EMIT;
            end else begin
              state  <= S_TEST_P;
              launch <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: split point, pair found flag, output register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire) begin
      n_reg  <= n_in;
      p      <= n_in[cgpp_pkg::NUM_WIDTH-1:1];
      q      <= n_in - {1'b0, n_in[cgpp_pkg::NUM_WIDTH-1:1]};
      res_ok <= 1'b0;
    end else if (state == S_TEST_Q && pt.done && pt.is_prime) begin
      res_ok <= 1'b1;
    end else if (step && !at_end) begin
      p <= p - 1'b1;
      q <= q + 1'b1;
    end
    if (emit_fire) begin
      out_valid_res <= res_ok;
      out_smaller   <= res_ok ? p : '0;
      out_larger    <= res_ok ? q : '0;
    end
  end

  assign in_ch.ready          = (state == S_IDLE);
  assign out_ch.valid         = out_valid;
  assign out_ch.valid_res     = out_valid_res;
  assign out_ch.smaller_prime = out_smaller;
  assign out_ch.larger_prime  = out_larger;

  `CGPP_ASSERT(a_pair_sum, (state == S_TEST_P) || (state == S_TEST_Q), (({1'b0, p} + q) == n_reg), "split point lost its sum")
  `CGPP_ASSERT(a_p_floor, (state == S_TEST_P) || (state == S_TEST_Q), ((p >> 1) != '0), "candidate below two")
  `CGPP_ASSERT_NXT(a_launch_busy, launch, pt.busy, "prime tester did not start")
  `CGPP_ASSERT(a_out_order, out_valid && out_valid_res, ({1'b0, out_smaller} <= out_larger), "pair out of order")
  `CGPP_ASSERT(a_out_zero, out_valid && !out_valid_res, ((out_smaller == '0) && (out_larger == '0)), "failed item carries primes")

endmodule
